// ===== rtl/tpcs_pkg.sv =====
// shared types, constants and the prescaler lookup function of the timer prescaler search
`default_nettype none

package tpcs_pkg;

  // datapath widths
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned CMP_W     = 16;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned PROD_W    = CMP_W + DUTY_W;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned SHIFT_W   = 4;

  // prescaler tables and search limits
  localparam int unsigned MAX_PRESCALE_STEPS_DEF = 7;
  localparam logic [SEL_W-1:0] TABLE_FIVE_LEN  = 3'd5;
  localparam logic [SEL_W-1:0] TABLE_SEVEN_LEN = 3'd7;

  // constants
  localparam logic [DIV_W-1:0] DUTY_DIV  = 32'd100;
  localparam logic [DIV_W-1:0] CLOCK_RST = 32'd16000000;
  localparam logic [CMP_W-1:0] CMP_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRY,
    ST_TRY_WAIT,
    ST_MUL,
    ST_DUTY,
    ST_DUTY_WAIT,
    ST_OUT
  } tpcs_state_e;

  // log2 of the prescaler at table position idx (every entry is a power of two)
  function automatic logic [SHIFT_W-1:0] prescale_shift(input logic seven,
                                                        input logic [SEL_W-1:0] idx);
    logic [SHIFT_W-1:0] sh;
    sh = '0;
    if (seven) begin
      unique case (idx)
        3'd0:    sh = 4'd0;
        3'd1:    sh = 4'd3;
        3'd2:    sh = 4'd5;
        3'd3:    sh = 4'd6;
        3'd4:    sh = 4'd7;
        3'd5:    sh = 4'd8;
        3'd6:    sh = 4'd10;
        default: sh = 4'd0;
      endcase
    end else begin
      unique case (idx)
        3'd0:    sh = 4'd0;
        3'd1:    sh = 4'd3;
        3'd2:    sh = 4'd6;
        3'd3:    sh = 4'd8;
        3'd4:    sh = 4'd10;
        default: sh = 4'd0;
      endcase
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/timer_prescaler_compare_search_top.sv =====
// top level of the timer prescaler and compare value search
`default_nettype none

// Finds the first prescaler whose compare value clock_hz/(k*p*freq_hz)-1 fits the
// limit (k=2 and compare_limit with compare output, else k=1 and a zero limit) and
// whose quotient is nonzero, walking the five- or seven-entry table in order, and
// returns the clock select, the compare value and a PWM duty compare.
// One request is worked at a time on a single 32-bit restoring divider that yields
// one quotient bit per cycle, used for each prescaler tried and then for the duty
// scaling. A zero frequency skips the divider and goes straight to the output
// state. The input stalls while a request is in work and takes the next beat in
// the cycle after the result is loaded; a finished result sits in an output
// register, so the next request can be taken while the result beat still waits
// downstream. A result that finds that register full and stalled waits, with the
// input stalled, until it drains. The user must write clock_hz only while idle;
// the block itself does not enforce it.
module timer_prescaler_compare_search_top #(
  parameter int unsigned MAX_PRESCALE_STEPS = tpcs_pkg::MAX_PRESCALE_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // clock_hz register write
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] freq_hz_i,
  input  wire logic        prescaler_set_i,
  input  wire logic        use_compare_i,
  input  wire logic [15:0] compare_limit_i,
  input  wire logic [6:0]  duty_percent_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             ok_o,
  output logic [2:0]       clock_select_o,
  output logic [15:0]      compare_value_o,
  output logic [15:0]      duty_compare_o
);

  localparam logic [tpcs_pkg::SEL_W-1:0] MaxSteps = tpcs_pkg::SEL_W'(MAX_PRESCALE_STEPS);

  tpcs_pkg::tpcs_state_e state_q, state_d;

  // configuration
  logic [31:0] clock_q;

  // latched request
  logic [31:0] freq_q;
  logic        set_q;
  logic        cmp_q;
  logic [15:0] limit_q;
  logic [6:0]  duty_q;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  steps_q;

  // working result
  logic        res_ok_q, res_ok_d;
  logic [2:0]  res_sel_q, res_sel_d;
  logic [15:0] res_val_q, res_val_d;
  logic [15:0] res_duty_q, res_duty_d;
  logic [tpcs_pkg::PROD_W-1:0] prod_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        ok_q;
  logic [2:0]  sel_q;
  logic [15:0] val_q;
  logic [15:0] dc_q;

  // divider hookup
  logic        div_start;
  logic        div_done;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [31:0] div_quo;

  logic        in_acc;
  logic        out_load;
  logic        latch_req;
  logic [2:0]  table_len;
  logic [tpcs_pkg::SHIFT_W-1:0] shift;
  logic [15:0] eff_limit;
  logic [31:0] val_full;
  logic        hit;
  logic [15:0] top_val;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != tpcs_pkg::ST_IDLE);
  assign out_load  = (state_q == tpcs_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);
  assign latch_req = in_acc;

  assign table_len = prescaler_set_i ? tpcs_pkg::TABLE_SEVEN_LEN : tpcs_pkg::TABLE_FIVE_LEN;

  // divisor doubling for compare output is one more shift of the clock
  assign shift = tpcs_pkg::prescale_shift(set_q, idx_q) + tpcs_pkg::SHIFT_W'(cmp_q);

  assign eff_limit = cmp_q ? limit_q : '0;
  assign val_full  = div_quo - 32'd1;
  assign hit       = (div_quo != '0) && (val_full <= {16'b0, eff_limit});
  assign top_val   = (res_val_q == '0) ? limit_q : res_val_q;

  // one divider: prescaler tries, then the duty scaling by 100
  assign div_start    = (state_q == tpcs_pkg::ST_TRY) || (state_q == tpcs_pkg::ST_DUTY);
  assign div_dividend = (state_q == tpcs_pkg::ST_DUTY) ?
                        {{(32 - tpcs_pkg::PROD_W){1'b0}}, prod_q} : (clock_q >> shift);
  assign div_divisor  = (state_q == tpcs_pkg::ST_DUTY) ? tpcs_pkg::DUTY_DIV : freq_q;

  tpcs_div #(
    .Width(tpcs_pkg::DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    res_ok_d   = res_ok_q;
    res_sel_d  = res_sel_q;
    res_val_d  = res_val_q;
    res_duty_d = res_duty_q;
    unique case (state_q)
      tpcs_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_d      = '0;
          res_ok_d   = 1'b0;
          res_sel_d  = '0;
          res_val_d  = '0;
          res_duty_d = '0;
          // zero frequency fails without a try
          state_d = (freq_hz_i == '0) ? tpcs_pkg::ST_OUT : tpcs_pkg::ST_TRY;
        end
      end
      tpcs_pkg::ST_TRY: begin
        state_d = tpcs_pkg::ST_TRY_WAIT;
      end
      tpcs_pkg::ST_TRY_WAIT: begin
        if (div_done) begin
          res_sel_d = idx_q + 3'd1;
          res_val_d = val_full[15:0];
          if (hit) begin
            res_ok_d = 1'b1;
            state_d  = tpcs_pkg::ST_MUL;
          end else if (idx_q == steps_q - 3'd1) begin
            state_d  = tpcs_pkg::ST_OUT;
          end else begin
            idx_d    = idx_q + 3'd1;
            state_d  = tpcs_pkg::ST_TRY;
          end
        end
      end
      tpcs_pkg::ST_MUL: begin
        state_d = tpcs_pkg::ST_DUTY;
      end
      tpcs_pkg::ST_DUTY: begin
        state_d = tpcs_pkg::ST_DUTY_WAIT;
      end
      tpcs_pkg::ST_DUTY_WAIT: begin
        if (div_done) begin
          // duty above 100 can overflow 16 bits
          res_duty_d = (div_quo > {16'b0, tpcs_pkg::CMP_MAX}) ? tpcs_pkg::CMP_MAX
                                                              : div_quo[15:0];
          state_d    = tpcs_pkg::ST_OUT;
        end
      end
      tpcs_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = tpcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpcs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      clock_q     <= tpcs_pkg::CLOCK_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        clock_q <= cfg_wdata_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (latch_req) begin
      freq_q  <= freq_hz_i;
      set_q   <= prescaler_set_i;
      cmp_q   <= use_compare_i;
      limit_q <= compare_limit_i;
      duty_q  <= duty_percent_i;
      steps_q <= (MaxSteps < table_len) ? MaxSteps : table_len;
    end
    idx_q      <= idx_d;
    res_ok_q   <= res_ok_d;
    res_sel_q  <= res_sel_d;
    res_val_q  <= res_val_d;
    res_duty_q <= res_duty_d;
    if (state_q == tpcs_pkg::ST_MUL) begin
      prod_q <= {{tpcs_pkg::DUTY_W{1'b0}}, top_val} *
                {{tpcs_pkg::CMP_W{1'b0}}, duty_q};
    end
    if (out_load) begin
      ok_q  <= res_ok_q;
      sel_q <= res_sel_q;
      val_q <= res_val_q;
      dc_q  <= res_duty_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign clock_select_o  = sel_q;
  assign compare_value_o = val_q;
  assign duty_compare_o  = dc_q;

endmodule

`default_nettype wire

// ===== rtl/tpcs_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module tpcs_div #(
  parameter int unsigned Width = tpcs_pkg::DIV_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  done_o,
  output logic [Width-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(Width);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [Width-1:0]  rem_q, rem_d;
  logic [Width-1:0]  quo_q, quo_d;
  logic [Width-1:0]  dsr_q, dsr_d;
  logic [Width:0]    rem_sh;
  logic [Width:0]    rem_sub;
  logic              last;

  assign rem_sh  = {rem_q, quo_q[Width-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign last    = (cnt_q == CntW'(Width - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // restoring step: keep the difference when it does not borrow
      if (!rem_sub[Width]) begin
        rem_d = rem_sub[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/tpcs_checker.sv =====
// port-level checks for the timer prescaler search, bound to the top level
`default_nettype none

module tpcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        ok_o,
  input wire logic [2:0]  clock_select_o,
  input wire logic [15:0] compare_value_o,
  input wire logic [15:0] duty_compare_o
);

  // an accepted request keeps the input stalled while it is worked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after request beat");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(ok_o) && $stable(clock_select_o) &&
       $stable(compare_value_o) && $stable(duty_compare_o)))
    else $error("stalled result beat changed");

  // a failed search reports no duty compare
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (duty_compare_o == '0))
    else $error("duty compare set on failure");

  // success always names a prescaler
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ok_o) |-> (clock_select_o != '0))
    else $error("success without clock select");

  // no prescaler tried means a zero frequency result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (clock_select_o == '0)) |-> (!ok_o && (compare_value_o == '0)))
    else $error("untried result not cleared");

endmodule

bind timer_prescaler_compare_search_top tpcs_checker u_tpcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .ok_o           (ok_o),
  .clock_select_o (clock_select_o),
  .compare_value_o(compare_value_o),
  .duty_compare_o (duty_compare_o)
);

`default_nettype wire

// ===== bench/timer_prescaler_compare_search_top_tb.sv =====
// self-checking bench for the timer prescaler and compare value search
`timescale 1ns / 1ps

module timer_prescaler_compare_search_top_tb;

  // one request beat and one result beat, in port order
  typedef struct packed {
    logic [31:0] freq_hz;
    logic        prescaler_set;
    logic        use_compare;
    logic [15:0] compare_limit;
    logic [6:0]  duty_percent;
  } timer_req_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  clock_select;
    logic [15:0] compare_value;
    logic [15:0] duty_compare;
  } timer_res_t;

  // cycles with no beat on either channel before the run is called hung
  localparam int unsigned HANG_LIMIT = 4000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [31:0] freq_hz_i       = '0;
  logic        prescaler_set_i = 1'b0;
  logic        use_compare_i   = 1'b0;
  logic [15:0] compare_limit_i = '0;
  logic [6:0]  duty_percent_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic        ok_o;
  logic [2:0]  clock_select_o;
  logic [15:0] compare_value_o;
  logic [15:0] duty_compare_o;

  // both sides stop idling while this is set
  logic        calm            = 1'b0;
  int unsigned requests_sent   = 0;
  int unsigned clock_settings  = 1;
  int unsigned quiet_cycles    = 0;

  timer_prescaler_compare_search_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .freq_hz_i       (freq_hz_i),
    .prescaler_set_i (prescaler_set_i),
    .use_compare_i   (use_compare_i),
    .compare_limit_i (compare_limit_i),
    .duty_percent_i  (duty_percent_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .clock_select_o  (clock_select_o),
    .compare_value_o (compare_value_o),
    .duty_compare_o  (duty_compare_o)
  );

  always #5 clk_i = ~clk_i;

  // prescaler at zero-based table position idx of the five- or seven-entry table
  function automatic int unsigned prescale_at(logic seven, int unsigned idx);
    int unsigned p;
    p = 1;
    case ({seven, 3'(idx)})
      4'b0_001: p = 8;
      4'b0_010: p = 64;
      4'b0_011: p = 256;
      4'b0_100: p = 1024;
      4'b1_001: p = 8;
      4'b1_010: p = 32;
      4'b1_011: p = 64;
      4'b1_100: p = 128;
      4'b1_101: p = 256;
      4'b1_110: p = 1024;
      default:  p = 1;
    endcase
    return p;
  endfunction

  // expected results in request order, plus the clock setting they depend on
  class result_board;
    timer_res_t  pending[$];
    logic [31:0] clock_hz = tpcs_pkg::CLOCK_RST;
    int unsigned errors   = 0;
    int unsigned checked  = 0;
    int unsigned found    = 0;
    int unsigned missed   = 0;

    // walk the table until a quotient is nonzero and its compare value fits
    function timer_res_t predict_timer(timer_req_t r);
      timer_res_t  res;
      logic [63:0] divisor, quot, cmp_val, ceiling, top, prod;
      int unsigned steps;
      res     = '0;
      cmp_val = '0;
      steps   = r.prescaler_set ? 7 : 5;
      if (steps > tpcs_pkg::MAX_PRESCALE_STEPS_DEF) steps = tpcs_pkg::MAX_PRESCALE_STEPS_DEF;
      // without compare output only an exact single-count period is accepted
      ceiling = r.use_compare ? 64'(r.compare_limit) : 64'd0;
      if (r.freq_hz != '0) begin
        for (int unsigned i = 0; i < steps && !res.ok; i++) begin
          divisor = (r.use_compare ? 64'd2 : 64'd1) * 64'(prescale_at(r.prescaler_set, i))
                    * 64'(r.freq_hz);
          quot    = 64'(clock_hz) / divisor;
          cmp_val = quot - 64'd1;
          res.clock_select = 3'(i + 1);
          if (quot != 64'd0 && cmp_val <= ceiling) res.ok = 1'b1;
        end
      end
      res.compare_value = cmp_val[15:0];
      if (res.ok) begin
        top  = (cmp_val == 64'd0) ? 64'(r.compare_limit) : cmp_val;
        prod = top * 64'(r.duty_percent) / 64'd100;
        res.duty_compare = (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
      end
      return res;
    endfunction

    function void note_request(timer_req_t r);
      timer_res_t want;
      want = predict_timer(r);
      if (want.ok) found++;
      else missed++;
      pending.push_back(want);
    endfunction

    task report_error(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    task check_result(timer_res_t got);
      timer_res_t want;
      if (pending.size() == 0) begin
        report_error("result beat with no request outstanding");
      end else begin
        want = pending.pop_front();
        if (got.ok !== want.ok)
          report_error($sformatf("result %0d ok got %b want %b", checked, got.ok, want.ok));
        if (got.clock_select !== want.clock_select)
          report_error($sformatf("result %0d clock_select got %0d want %0d", checked,
                                 got.clock_select, want.clock_select));
        if (got.compare_value !== want.compare_value)
          report_error($sformatf("result %0d compare_value got %h want %h", checked,
                                 got.compare_value, want.compare_value));
        if (got.duty_compare !== want.duty_compare)
          report_error($sformatf("result %0d duty_compare got %h want %h", checked,
                                 got.duty_compare, want.duty_compare));
        checked++;
      end
    endtask
  endclass

  result_board board = new;

  // random request for the current clock; most are aimed at a prescaler that can work
  function automatic timer_req_t random_request(logic [31:0] hz);
    timer_req_t  r;
    int unsigned pick, idx;
    logic [63:0] denom, target;
    r.prescaler_set = 1'($urandom_range(1));
    r.use_compare   = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 10)      r.compare_limit = '0;
    else if (pick < 20) r.compare_limit = 16'hFFFF;
    else if (pick < 50) r.compare_limit = 16'($urandom_range(255));
    else                r.compare_limit = 16'($urandom);
    // a quarter of the requests may ask for a duty above 100
    r.duty_percent = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                              : 7'($urandom_range(100));
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.freq_hz = '0;
    end else if (pick < 18) begin
      r.freq_hz = $urandom;
    end else if (pick < 30) begin
      r.freq_hz = $urandom_range(50000, 1);
    end else begin
      // pick a table entry and a compare count near the limit, derive the frequency
      idx    = $urandom_range(r.prescaler_set ? 6 : 4);
      target = r.use_compare ? 64'($urandom_range(32'(r.compare_limit) + 32'd1) + 1) : 64'd1;
      denom  = (r.use_compare ? 64'd2 : 64'd1) * 64'(prescale_at(r.prescaler_set, idx))
               * target;
      r.freq_hz = 32'(64'(hz) / denom);
      if ($urandom_range(3) == 0) r.freq_hz = r.freq_hz + 32'($urandom_range(2)) - 32'd1;
      if (r.freq_hz == '0) r.freq_hz = 32'd1;
    end
    return r;
  endfunction

  // present one request beat and hold it until it is taken
  task automatic send_request(input timer_req_t r);
    int unsigned gap;
    gap = 0;
    if (!calm) begin
      // now and then a long gap so idling lands in every phase of the search
      if ($urandom_range(49) == 0) gap = $urandom_range(300, 1);
      while ($urandom_range(99) < 37) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    freq_hz_i       <= r.freq_hz;
    prescaler_set_i <= r.prescaler_set;
    use_compare_i   <= r.use_compare;
    compare_limit_i <= r.compare_limit;
    duty_percent_i  <= r.duty_percent;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(r);
    requests_sent++;
  endtask

  // drop valid and wait for every outstanding result beat
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // clock_hz changes only with the block idle
  task automatic write_clock(input logic [31:0] hz);
    drain_results();
    // let the block sit idle ahead of the write
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.clock_hz = hz;
    clock_settings++;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned calm_count);
    for (int unsigned n = 0; n < count; n++) begin
      calm <= (n < calm_count);
      // sender holds off until the block has handed back everything
      if (n % 113 == 57) drain_results();
      send_request(random_request(board.clock_hz));
    end
    calm <= 1'b0;
  endtask

  // result side: take beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result('{ok_o, clock_select_o, compare_value_o, duty_compare_o});
    out_stall_i <= !calm && ($urandom_range(99) < 37);
  end

  // hang detection: no beat on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("no beat for %0d cycles, %0d results outstanding", quiet_cycles,
               board.pending.size());
      $display("timer_prescaler_compare_search_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset clock of 16 MHz
    send_request('{32'd0, 1'b0, 1'b1, 16'd100, 7'd50});         // zero frequency
    send_request('{32'd0, 1'b1, 1'b0, 16'hFFFF, 7'd127});
    send_request('{32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF, 7'd50});  // zero quotient everywhere
    send_request('{32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 7'd0});
    send_request('{32'd16000000, 1'b0, 1'b0, 16'd1000, 7'd25});  // exact count, top is limit
    send_request('{32'd2000000, 1'b0, 1'b0, 16'd0, 7'd100});     // exact count at second entry
    send_request('{32'd2000000, 1'b1, 1'b0, 16'd500, 7'd100});
    send_request('{32'd8000000, 1'b0, 1'b1, 16'hFFFF, 7'd127});  // duty saturates
    send_request('{32'd8000000, 1'b1, 1'b1, 16'hFFFF, 7'd101});
    send_request('{32'd8000000, 1'b0, 1'b1, 16'd0, 7'd100});
    send_request('{32'd1000, 1'b0, 1'b1, 16'hFFFF, 7'd50});
    send_request('{32'd1000, 1'b1, 1'b1, 16'd255, 7'd33});       // lands on the 32 entry
    send_request('{32'd1000, 1'b0, 1'b1, 16'd255, 7'd33});
    send_request('{32'd62500, 1'b1, 1'b1, 16'd0, 7'd10});        // lands on the 128 entry
    send_request('{32'd1, 1'b0, 1'b1, 16'hFFFF, 7'd99});
    send_request('{32'd1, 1'b1, 1'b1, 16'd0, 7'd0});             // runs out of entries
    send_request('{32'd1, 1'b0, 1'b0, 16'hFFFF, 7'd127});
    send_request('{32'd7813, 1'b0, 1'b0, 16'h5555, 7'h55});
    send_request('{32'h5555_5555, 1'b1, 1'b1, 16'hAAAA, 7'h2A});
    send_request('{32'hAAAA_AAAA, 1'b0, 1'b1, 16'h5555, 7'h55});

    run_random(300, 0);
    write_clock(32'hFFFF_FFFF);
    run_random(200, 0);
    write_clock(32'd1);
    run_random(60, 0);
    write_clock(32'd0);
    run_random(40, 0);
    write_clock(32'd20000000);
    run_random(250, 150);
    write_clock($urandom_range(32'hFFFF_FFFF, 1));
    run_random(250, 0);
    write_clock(32'd12000000);
    run_random(250, 0);

    drain_results();
    repeat (40) @(posedge clk_i);
    $display("%0d requests over %0d clock settings: %0d found a prescaler, %0d did not",
             requests_sent, clock_settings, board.found, board.missed);
    $display("%0d result beats checked, %0d field errors", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("timer_prescaler_compare_search_top: match");
    end else begin
      $display("timer_prescaler_compare_search_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== timer_prescaler_compare_search_top.f =====
rtl/tpcs_pkg.sv
rtl/tpcs_div.sv
rtl/timer_prescaler_compare_search_top.sv
rtl/tpcs_checker.sv
bench/timer_prescaler_compare_search_top_tb.sv
